/* design/tmsf_pkg.sv */
// Shared constants and types for the trimmed-mean sample filter.
package tmsf_pkg;

  // Largest number of samples in one burst.
  localparam int unsigned MAX_BURST  = 64;
  // Smallest burst: one minimum, one maximum and at least one inner sample.
  localparam int unsigned MIN_BURST  = 3;
  // Sample and result width.
  localparam int unsigned SAMPLE_W   = 16;
  // Width of the burst length register.
  localparam int unsigned CFG_W      = 7;
  // Reset value of the burst length register.
  localparam int unsigned CFG_RESET  = 10;

  // Sample counter holds 0..MAX_BURST.
  localparam int unsigned IDX_W      = $clog2(MAX_BURST + 1);
  // The running sum holds MAX_BURST full-scale samples.
  localparam int unsigned SUM_W      = SAMPLE_W + $clog2(MAX_BURST);
  // The shared unit carries one extra bit, whose top bit is the borrow.
  localparam int unsigned ALU_W      = SUM_W + 1;
  // Width used to compare the sample counter against the burst length.
  localparam int unsigned LEN_W      = (IDX_W > CFG_W) ? IDX_W : CFG_W;
  // Counter over the quotient bits of the closing division.
  localparam int unsigned DIV_CNT_W  = $clog2(SUM_W);

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_CMP_MIN,
    ST_CMP_MAX,
    ST_SUB_MIN,
    ST_SUB_MAX,
    ST_DIV
  } tmsf_state_e;

endpackage

/* design/trimmed_mean_sample_filter.sv */
// Trimmed-mean sample filter: burst accumulation and closing division on one shared adder.
//
// Usage: a sample is transferred on sample_i at a rising edge where start is high and
// busy is low. The burst length is written through the cfg channel (sample_count_i,
// cfg_valid_i / cfg_ready_o); cfg_ready_o is always high, and the value is saturated
// to 3..64 when used. A new length applies at once and does not restart the burst.
// Every sample runs through one add/subtract unit under a small sequencer: the add
// into the running sum, the compare against the minimum and the compare against the
// maximum are each a state of their own, and busy stays high until they are done, so
// a new sample cannot be transferred before the last one is through. The sample that
// closes a burst then removes the minimum and maximum and divides by the sample
// count less two with a restoring divider on the same unit, one quotient bit per
// cycle, with busy high throughout. The result is shown on average_o, marked by
// avg_valid_o for exactly one cycle, in the cycle in which busy falls; the receiver
// cannot stall and must take it then. After reset the burst is empty, the length
// register holds 10, and no result is pending.
module trimmed_mean_sample_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [tmsf_pkg::SAMPLE_W-1:0] sample_i,
  output logic                          avg_valid_o,
  output logic [tmsf_pkg::SAMPLE_W-1:0] average_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tmsf_pkg::CFG_W-1:0]    sample_count_i
);
  import tmsf_pkg::*;

  tmsf_state_e              state_q, state_d;
  logic [CFG_W-1:0]         cfg_q;
  logic [IDX_W-1:0]         idx_q;
  logic [SUM_W-1:0]         sum_q;
  logic [SAMPLE_W-1:0]      min_q;
  logic [SAMPLE_W-1:0]      max_q;
  logic [SAMPLE_W-1:0]      samp_q;
  logic [IDX_W-1:0]         rem_q;
  logic [IDX_W-1:0]         div_q;
  logic [DIV_CNT_W-1:0]     cnt_q;
  logic                     avg_valid_q;
  logic [SAMPLE_W-1:0]      avg_q;

  logic [ALU_W-1:0]         alu_a;
  logic [ALU_W-1:0]         alu_b;
  logic                     alu_sub;
  logic [ALU_W-1:0]         alu_res;
  logic                     alu_borrow;
  logic [LEN_W-1:0]         cfg_ext;
  logic [LEN_W-1:0]         eff_len;
  logic [LEN_W-1:0]         taken;
  logic                     burst_done;
  logic [IDX_W:0]           partial;
  logic                     accept;

  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign avg_valid_o = avg_valid_q;
  assign average_o   = avg_q;

  // Effective burst length, saturated to the legal range.
  always_comb begin
    cfg_ext = LEN_W'(cfg_q);
    if (cfg_ext < LEN_W'(MIN_BURST)) begin
      eff_len = LEN_W'(MIN_BURST);
    end else if (cfg_ext > LEN_W'(MAX_BURST)) begin
      eff_len = LEN_W'(MAX_BURST);
    end else begin
      eff_len = cfg_ext;
    end
  end

  // The burst closes once the count including this sample reaches the length.
  assign taken      = LEN_W'(idx_q) + LEN_W'(1);
  assign burst_done = (taken >= eff_len);

  // Partial remainder with the next dividend bit shifted in.
  assign partial = {rem_q, sum_q[SUM_W-1]};

  // Shared add/subtract unit; the top bit flags a borrow on subtraction.
  assign alu_res    = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  assign alu_borrow = alu_res[ALU_W-1];

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_ADD;
      end
      ST_ADD:     state_d = ST_CMP_MIN;
      ST_CMP_MIN: state_d = ST_CMP_MAX;
      ST_CMP_MAX: state_d = burst_done ? ST_SUB_MIN : ST_IDLE;
      ST_SUB_MIN: state_d = ST_SUB_MAX;
      ST_SUB_MAX: state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == '0) state_d = ST_IDLE;
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  // Output decode: operand selection for the shared unit and the busy flag.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    busy    = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_ADD: begin
        alu_a   = ALU_W'(sum_q);
        alu_b   = ALU_W'(samp_q);
        alu_sub = 1'b0;
      end
      ST_CMP_MIN: begin
        alu_a = ALU_W'(samp_q);
        alu_b = ALU_W'(min_q);
      end
      ST_CMP_MAX: begin
        alu_a = ALU_W'(max_q);
        alu_b = ALU_W'(samp_q);
      end
      ST_SUB_MIN: begin
        alu_a = ALU_W'(sum_q);
        alu_b = ALU_W'(min_q);
      end
      ST_SUB_MAX: begin
        alu_a = ALU_W'(sum_q);
        alu_b = ALU_W'(max_q);
      end
      ST_DIV: begin
        alu_a = ALU_W'(partial);
        alu_b = ALU_W'(div_q);
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // Control and burst state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= CFG_W'(CFG_RESET);
      idx_q       <= '0;
      sum_q       <= '0;
      min_q       <= '1;
      max_q       <= '0;
      cnt_q       <= '0;
      avg_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      // The result strobe follows the last division step.
      avg_valid_q <= (state_q == ST_DIV) && (cnt_q == '0);
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= sample_count_i;
      end
      case (state_q)
        ST_ADD: begin
          sum_q <= alu_res[SUM_W-1:0];
        end
        ST_CMP_MIN: begin
          if (alu_borrow) min_q <= samp_q;
        end
        ST_CMP_MAX: begin
          if (alu_borrow) max_q <= samp_q;
          idx_q <= taken[IDX_W-1:0];
        end
        ST_SUB_MIN: begin
          sum_q <= alu_res[SUM_W-1:0];
        end
        ST_SUB_MAX: begin
          sum_q <= alu_res[SUM_W-1:0];
          cnt_q <= DIV_CNT_W'(SUM_W - 1);
        end
        ST_DIV: begin
          cnt_q <= cnt_q - DIV_CNT_W'(1);
          if (cnt_q == '0) begin
            idx_q <= '0;
            sum_q <= '0;
            min_q <= '1;
            max_q <= '0;
          end else begin
            // Quotient bits shift in where the dividend bits leave.
            sum_q <= {sum_q[SUM_W-2:0], !alu_borrow};
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      samp_q <= sample_i;
    end
    case (state_q)
      ST_SUB_MAX: begin
        rem_q <= '0;
        div_q <= idx_q - IDX_W'(2);
      end
      ST_DIV: begin
        // Restoring step: keep the difference when no borrow occurred.
        rem_q <= alu_borrow ? partial[IDX_W-1:0] : alu_res[IDX_W-1:0];
        if (cnt_q == '0) begin
          avg_q <= {sum_q[SAMPLE_W-2:0], !alu_borrow};
        end
      end
      default: begin
      end
    endcase
  end

  // A result only appears once the sequencer is back at rest.
  assert property (@(posedge clk_i) disable iff (!rst_ni) avg_valid_o |-> !busy)
    else $error("result strobe while busy");

  // Each result strobe lasts exactly one cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) avg_valid_o |=> !avg_valid_o)
    else $error("result strobe longer than one cycle");

  // A transfer always starts the sequencer.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("accepted sample did not start the sequencer");

  // The burst is empty whenever a result is delivered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   avg_valid_o |-> (idx_q == '0 && sum_q == '0))
    else $error("burst not cleared after result");

  // During division the divisor is nonzero and the remainder stays below it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == ST_DIV) |-> (div_q != '0 && rem_q < div_q))
    else $error("division remainder out of range");

endmodule
